>>> hw/rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Types and constants for the segment rotate-about-pivot core.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int COORD_W    = 24;
  localparam int ANGLE_W    = 16;
  localparam int GUARD_BITS = 6;
  localparam int DATA_W     = 34;
  localparam int Z_W        = 34;
  localparam int PROD_W     = 64;
  localparam int MAX_STAGES = 32;
  localparam int RES_W      = PROD_W - 30 - GUARD_BITS;
  localparam int SUM_W      = RES_W + 1;

  // gain 0.6072529350 in Q30
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ATAN_LUT [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [DATA_W-1:0]  x0;
    logic signed [DATA_W-1:0]  y0;
    logic signed [DATA_W-1:0]  x1;
    logic signed [DATA_W-1:0]  y1;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } sra_pipe_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_first_x;
    logic signed [COORD_W-1:0] new_first_y;
    logic signed [COORD_W-1:0] new_second_x;
    logic signed [COORD_W-1:0] new_second_y;
    logic                      clipped;
  } sra_result_t;

endpackage

>>> hw/rtl/sra_if.sv
// ----------------------------------------------------------------------------
// sra_in_if / sra_out_if
// Valid/ready channels for segment transactions and rotated results.
// ----------------------------------------------------------------------------
interface sra_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] first_x;
  logic signed [23:0] first_y;
  logic signed [23:0] second_x;
  logic signed [23:0] second_y;
  logic signed [23:0] pivot_x;
  logic signed [23:0] pivot_y;
  logic [15:0]        turn_angle;

  modport source (output valid, first_x, first_y, second_x, second_y, pivot_x, pivot_y,
                  turn_angle, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, pivot_x, pivot_y,
                turn_angle, output ready);
endinterface

interface sra_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] new_first_x;
  logic signed [23:0] new_first_y;
  logic signed [23:0] new_second_x;
  logic signed [23:0] new_second_y;
  logic               clipped;

  modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                  clipped, input ready);
  modport sink (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                clipped, output ready);
endinterface

>>> hw/rtl/segment_rotate_about_pivot_core.sv
// ----------------------------------------------------------------------------
// segment_rotate_about_pivot_core
// Rotates both endpoints of a segment about a pivot with a pipelined CORDIC.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   in_seg   | in  | valid / ready | two endpoints, pivot, turn_angle
//   out_seg  | out | valid / ready | two rotated endpoints, clipped flag
//
// The pipeline registers are the angle fold, one cell per CORDIC stage, the
// gain product and the output register. One transaction per cycle while no held result stalls the chain.
// The whole chain advances when the output register is empty or taken; a
// held result freezes every stage. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module segment_rotate_about_pivot_core
  import sra_pkg::*;
#(
  parameter int ROTATION_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sra_in_if.sink    in_seg,
  sra_out_if.source out_seg
);

  logic        en;
  logic        prep_valid_r;
  sra_pipe_t   prep_r;
  sra_pipe_t   prep_nxt;
  logic        neg;
  logic signed [ANGLE_W-1:0] resid;
  logic signed [COORD_W:0]   d0x, d0y, d1x, d1y;

  logic      cell_valid [ROTATION_STAGES+1];
  sra_pipe_t cell_data  [ROTATION_STAGES+1];

  logic        res_valid;
  sra_result_t res;

  assign en           = !res_valid || out_seg.ready;
  assign in_seg.ready = en;

  function automatic logic signed [DATA_W-1:0] scale_off(
    input logic signed [COORD_W:0] d,
    input logic                    flip
  );
    logic signed [DATA_W-1:0] v;
    begin
      v = DATA_W'(d) <<< GUARD_BITS;
      scale_off = flip ? -v : v;
    end
  endfunction

  always_comb begin
    neg   = in_seg.turn_angle[ANGLE_W-1] ^ in_seg.turn_angle[ANGLE_W-2];
    resid = {in_seg.turn_angle[ANGLE_W-1] ^ neg, in_seg.turn_angle[ANGLE_W-2:0]};
    d0x = (COORD_W+1)'(in_seg.first_x)  - (COORD_W+1)'(in_seg.pivot_x);
    d0y = (COORD_W+1)'(in_seg.first_y)  - (COORD_W+1)'(in_seg.pivot_y);
    d1x = (COORD_W+1)'(in_seg.second_x) - (COORD_W+1)'(in_seg.pivot_x);
    d1y = (COORD_W+1)'(in_seg.second_y) - (COORD_W+1)'(in_seg.pivot_y);
    prep_nxt.x0 = scale_off(d0x, neg);
    prep_nxt.y0 = scale_off(d0y, neg);
    prep_nxt.x1 = scale_off(d1x, neg);
    prep_nxt.y1 = scale_off(d1y, neg);
    prep_nxt.z  = Z_W'(resid) <<< 16;
    prep_nxt.px = in_seg.pivot_x;
    prep_nxt.py = in_seg.pivot_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (en) begin
      prep_valid_r <= in_seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign cell_valid[0] = prep_valid_r;
  assign cell_data[0]  = prep_r;

  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    sra_cell #(
      .STAGE (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (cell_valid[g]),
      .data_i  (cell_data[g]),
      .valid_o (cell_valid[g+1]),
      .data_o  (cell_data[g+1])
    );
  end

  sra_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (cell_valid[ROTATION_STAGES]),
    .data_i   (cell_data[ROTATION_STAGES]),
    .valid_o  (res_valid),
    .result_o (res)
  );

  assign out_seg.valid        = res_valid;
  assign out_seg.new_first_x  = res.new_first_x;
  assign out_seg.new_first_y  = res.new_first_y;
  assign out_seg.new_second_x = res.new_second_x;
  assign out_seg.new_second_y = res.new_second_y;
  assign out_seg.clipped      = res.clipped;

endmodule

>>> hw/rtl/sra_cell.sv
// ----------------------------------------------------------------------------
// sra_cell
// One CORDIC rotation stage for both endpoints, sharing the angle residual.
// ----------------------------------------------------------------------------
module sra_cell
  import sra_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      valid_i,
  input  sra_pipe_t data_i,
  output logic      valid_o,
  output sra_pipe_t data_o
);

  localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN_LUT[STAGE]);

  logic              valid_r;
  sra_pipe_t         data_r;
  sra_pipe_t         data_nxt;
  logic signed [DATA_W-1:0] x0, y0, x1, y1;
  logic signed [Z_W-1:0]    z;

  always_comb begin
    x0 = data_i.x0;
    y0 = data_i.y0;
    x1 = data_i.x1;
    y1 = data_i.y1;
    z  = data_i.z;
    data_nxt = data_i;
    if (!z[Z_W-1]) begin
      data_nxt.x0 = x0 - (y0 >>> STAGE);
      data_nxt.y0 = y0 + (x0 >>> STAGE);
      data_nxt.x1 = x1 - (y1 >>> STAGE);
      data_nxt.y1 = y1 + (x1 >>> STAGE);
      data_nxt.z  = z - ATAN_Z;
    end else begin
      data_nxt.x0 = x0 + (y0 >>> STAGE);
      data_nxt.y0 = y0 - (x0 >>> STAGE);
      data_nxt.x1 = x1 + (y1 >>> STAGE);
      data_nxt.y1 = y1 - (x1 >>> STAGE);
      data_nxt.z  = z + ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> hw/rtl/sra_gain.sv
// ----------------------------------------------------------------------------
// sra_gain
// CORDIC gain correction, rounding, pivot add-back and saturation.
// Product stage followed by the output register.
// ----------------------------------------------------------------------------
module sra_gain
  import sra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        valid_i,
  input  sra_pipe_t   data_i,
  output logic        valid_o,
  output sra_result_t result_o
);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (29 + GUARD_BITS));

  logic                      prod_valid_r;
  logic signed [PROD_W-1:0]  p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic                      out_valid_r;
  sra_result_t               result_r;
  sra_result_t               result_nxt;
  logic                      c0x, c0y, c1x, c1y;

  function automatic logic signed [COORD_W-1:0] fix_coord(
    input logic signed [PROD_W-1:0]  prod,
    input logic signed [COORD_W-1:0] pivot,
    output logic                     clip
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [RES_W-1:0]  r;
    logic signed [SUM_W-1:0]  s;
    begin
      rnd = prod + ROUND_HALF;
      r   = rnd[PROD_W-1 -: RES_W];
      s   = SUM_W'(pivot) + SUM_W'(r);
      clip = 1'b0;
      if (s > SUM_W'(COORD_MAX)) begin
        clip = 1'b1;
        fix_coord = COORD_MAX;
      end else if (s < SUM_W'(COORD_MIN)) begin
        clip = 1'b1;
        fix_coord = COORD_MIN;
      end else begin
        fix_coord = s[COORD_W-1:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p0x_r <= PROD_W'(data_i.x0) * PROD_W'(GAIN_Q30);
      p0y_r <= PROD_W'(data_i.y0) * PROD_W'(GAIN_Q30);
      p1x_r <= PROD_W'(data_i.x1) * PROD_W'(GAIN_Q30);
      p1y_r <= PROD_W'(data_i.y1) * PROD_W'(GAIN_Q30);
      px_r  <= data_i.px;
      py_r  <= data_i.py;
    end
  end

  always_comb begin
    result_nxt.new_first_x  = fix_coord(p0x_r, px_r, c0x);
    result_nxt.new_first_y  = fix_coord(p0y_r, py_r, c0y);
    result_nxt.new_second_x = fix_coord(p1x_r, px_r, c1x);
    result_nxt.new_second_y = fix_coord(p1y_r, py_r, c1y);
    result_nxt.clipped      = c0x | c0y | c1x | c1y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= valid_i;
      out_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

  assign valid_o  = out_valid_r;
  assign result_o = result_r;

endmodule
